### hdl/tctr_pkg.sv
// ----------------------------------------------------------------------------
// tctr_pkg: shared types and constants for the TEA counter-mode cipher
// Lane record carried through the round chain, register indexes, round sums.
// ----------------------------------------------------------------------------
package tctr_pkg;

  localparam int unsigned ROUND_COUNT = 32;
  // each round is split into two half-round cells
  localparam int unsigned CELL_COUNT  = 2 * ROUND_COUNT;

  localparam logic [31:0] TEA_DELTA = 32'h9E3779B9;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_0    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_1    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_2    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_3    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_START_COUNTER = 3'd4;

  typedef struct packed {
    logic        valid;
    logic [7:0]  data;
    logic        last;
    logic [2:0]  pos;
    logic [31:0] x;   // word being updated by the next cell
    logic [31:0] y;   // word feeding the round function
  } tctr_lane_t;

  // running sum after round r (0-based), evaluated at elaboration
  function automatic logic [31:0] tea_sum(input int unsigned r);
    logic [63:0] prod;
    prod = 64'(TEA_DELTA) * 64'(r + 1);
    return prod[31:0];
  endfunction

endpackage

### hdl/tctr_cell.sv
// ----------------------------------------------------------------------------
// tctr_cell: one TEA half-round
// x += F(y); the two words swap on the way out so every cell looks the same.
// ----------------------------------------------------------------------------
module tctr_cell
  import tctr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic [31:0] key_a,
  input  logic [31:0] key_b,
  input  logic [31:0] sum,
  input  tctr_lane_t  lane_in,
  output tctr_lane_t  lane_out
);

  logic [31:0] mix;
  logic [31:0] x_next;

  assign mix    = ((lane_in.y << 4) + key_a) ^ (lane_in.y + sum) ^
                  ((lane_in.y >> 5) + key_b);
  assign x_next = lane_in.x + mix;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.valid <= 1'b0;
    end else if (advance) begin
      lane_out.valid <= lane_in.valid;
      lane_out.data  <= lane_in.data;
      lane_out.last  <= lane_in.last;
      lane_out.pos   <= lane_in.pos;
      lane_out.x     <= lane_in.y;
      lane_out.y     <= x_next;
    end
  end

endmodule

### hdl/tctr_ctrl.sv
// ----------------------------------------------------------------------------
// tctr_ctrl: input skid stage and counter tracking
// Tracks byte position and block index, loads the counter into the chain.
// ----------------------------------------------------------------------------
module tctr_ctrl
  import tctr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        msg_last,
  input  logic [63:0] start_counter,
  output tctr_lane_t  entry
);

  logic        hold_valid;
  logic [7:0]  hold_data;
  logic        hold_last;
  logic        src_valid;
  logic [7:0]  src_data;
  logic        src_last;
  logic        take;
  logic [2:0]  byte_position;
  logic [63:0] block_index;
  logic [63:0] counter;

  assign in_ready  = !hold_valid;
  assign src_valid = hold_valid | in_valid;
  assign src_data  = hold_valid ? hold_data : data_byte;
  assign src_last  = hold_valid ? hold_last : msg_last;
  assign take      = advance & src_valid;
  assign counter   = start_counter + block_index;

  // skid: catch a transaction that arrives while the chain is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end else if (in_valid && !hold_valid) begin
      hold_valid <= 1'b1;
      hold_data  <= data_byte;
      hold_last  <= msg_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 3'd0;
      block_index   <= 64'd0;
    end else if (take) begin
      if (src_last) begin
        byte_position <= 3'd0;
        block_index   <= 64'd0;
      end else begin
        byte_position <= byte_position + 3'd1;
        if (byte_position == 3'd0) begin
          block_index <= block_index + 64'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (advance) begin
      entry.valid <= src_valid;
      entry.data  <= src_data;
      entry.last  <= src_last;
      entry.pos   <= byte_position;
      entry.x     <= counter[31:0];
      entry.y     <= counter[63:32];
    end
  end

endmodule

### hdl/tea_counter_mode_stream_cipher_top.sv
// ----------------------------------------------------------------------------
// tea_counter_mode_stream_cipher_top: TEA counter-mode byte-stream cipher
// Byte in, byte out; encrypt and decrypt are the same operation.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one byte and its end-of-message flag per
//   transaction; out_valid/out_ready return the XORed byte and the flag in
//   the same order. cfg_we/cfg_index/cfg_data write the four key words
//   (indexes 0..3) and the start counter (index 4); write only while idle.
//   Every byte travels with its counter value through a row of 64
//   half-round cells (32 TEA rounds) into the output register, and one
//   byte is accepted every cycle while the receiver does not stall.
//   Bytes at the start of an 8-byte group latch their freshly enciphered
//   block at the chain end; the other bytes reuse that block.
//   A stalled receiver freezes the whole chain; a one-entry skid stage on
//   the input takes one more transaction, so in_ready is a register.
//   Reset clears the configuration, the position and block counters and
//   all valid bits; the first byte after reset starts a message.
// ----------------------------------------------------------------------------
module tea_counter_mode_stream_cipher_top
  import tctr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             data_byte,
  input  logic                   msg_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_last
);

  logic [31:0] key_word_0;
  logic [31:0] key_word_1;
  logic [31:0] key_word_2;
  logic [31:0] key_word_3;
  logic [63:0] start_counter;
  logic [63:0] keystream_block;
  logic [63:0] block_sel;
  logic        advance;
  tctr_lane_t  lane [CELL_COUNT+1];
  tctr_lane_t  tail;

  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word_0    <= 32'd0;
      key_word_1    <= 32'd0;
      key_word_2    <= 32'd0;
      key_word_3    <= 32'd0;
      start_counter <= 64'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_WORD_0:    key_word_0    <= cfg_data[31:0];
        REG_KEY_WORD_1:    key_word_1    <= cfg_data[31:0];
        REG_KEY_WORD_2:    key_word_2    <= cfg_data[31:0];
        REG_KEY_WORD_3:    key_word_3    <= cfg_data[31:0];
        REG_START_COUNTER: start_counter <= cfg_data;
        default: ;
      endcase
    end
  end

  tctr_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .msg_last      (msg_last),
    .start_counter (start_counter),
    .entry         (lane[0])
  );

  for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
    tctr_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .key_a    ((k % 2 == 0) ? key_word_0 : key_word_2),
      .key_b    ((k % 2 == 0) ? key_word_1 : key_word_3),
      .sum      (tea_sum(k / 2)),
      .lane_in  (lane[k]),
      .lane_out (lane[k+1])
    );
  end

  assign tail = lane[CELL_COUNT];
  // after an even number of swaps x is the low word again
  assign block_sel = (tail.pos == 3'd0) ? {tail.y, tail.x} : keystream_block;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      keystream_block <= 64'd0;
    end else if (advance) begin
      out_valid <= tail.valid;
      out_byte  <= tail.data ^ block_sel[{tail.pos, 3'b000} +: 8];
      out_last  <= tail.last;
      if (tail.valid && tail.pos == 3'd0) begin
        keystream_block <= {tail.y, tail.x};
      end
    end
  end

`ifndef SYNTHESIS
  // skid entry is only occupied after a stalled cycle
  a_skid_after_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> $past(!advance))
    else $error("skid stage filled without a stall");

  // a result only appears when the chain end held a transaction
  a_out_from_chain: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(tail.valid))
    else $error("result without a transaction at the chain end");

  // ready drops only after an accepted transaction
  a_ready_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid))
    else $error("in_ready fell without an input transaction");
`endif

endmodule

### test/tea_counter_mode_stream_cipher_top_tb.sv
// ----------------------------------------------------------------------------
// tea_counter_mode_stream_cipher_top_tb: self-checking bench for the TEA CTR cipher
// A directed byte table, then random messages over several key and counter
// settings and idle patterns. Every output byte is checked against a
// TEA counter-mode keystream predictor.
// ----------------------------------------------------------------------------
module tea_counter_mode_stream_cipher_top_tb;
  import tctr_pkg::*;

  localparam int unsigned PHASE_COUNT = 11;
  localparam int unsigned PHASE_ITEMS = 96;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 80;
  localparam int unsigned MAX_PRINTS  = 100;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cipher_out_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       want_last;
  } byte_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [63:0]            cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [7:0]             data_byte;
  logic                   msg_last;
  logic                   out_valid;
  logic                   out_ready;
  logic [7:0]             out_byte;
  logic                   out_last;

  // predictor state
  logic [31:0] key_w0, key_w1, key_w2, key_w3;
  logic [63:0] ctr_base;
  logic [63:0] ks_block;
  logic [2:0]  ks_pos;
  logic [63:0] blk_count;

  cipher_out_t expected_q[$];
  cipher_out_t head_r;
  int unsigned mismatch_count = 0;
  idle_mode_t  idle_mode = IDLE_NONE;
  int unsigned hold_left = 0;
  int unsigned msg_left = 0;

  // bytes 0..7 fill one block, 8..9 end a message at position 1, then
  // single-byte messages, a message ending at position 7, and an open tail
  localparam int unsigned DIR_ROWS = 23;
  localparam byte_row_t byte_table [DIR_ROWS] = '{
    '{8'h00, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0}, '{8'h55, 1'b0, 1'b0},
    '{8'hAA, 1'b0, 1'b0}, '{8'h01, 1'b0, 1'b0}, '{8'h80, 1'b0, 1'b0},
    '{8'h0F, 1'b0, 1'b0}, '{8'hF0, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},
    '{8'hFF, 1'b1, 1'b1}, '{8'hFF, 1'b1, 1'b1}, '{8'h00, 1'b1, 1'b1},
    '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b1, 1'b1}, '{8'h11, 1'b0, 1'b0},
    '{8'h22, 1'b0, 1'b0}, '{8'h33, 1'b0, 1'b0}
  };

  tea_counter_mode_stream_cipher_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .msg_last  (msg_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] tea_block(input logic [63:0] ctr);
    logic [31:0] v0, v1, sum;
    v0  = ctr[31:0];
    v1  = ctr[63:32];
    sum = 32'd0;
    for (int r = 0; r < ROUND_COUNT; r++) begin
      sum = sum + TEA_DELTA;
      v0  = v0 + (((v1 << 4) + key_w0) ^ (v1 + sum) ^ ((v1 >> 5) + key_w1));
      v1  = v1 + (((v0 << 4) + key_w2) ^ (v0 + sum) ^ ((v0 >> 5) + key_w3));
    end
    return {v1, v0};
  endfunction

  function automatic cipher_out_t cipher_step(input logic [7:0] d, input logic l);
    cipher_out_t r;
    if (ks_pos == 3'd0) begin
      ks_block  = tea_block(ctr_base + blk_count);
      blk_count = blk_count + 64'd1;
    end
    r.data = d ^ ks_block[8*ks_pos +: 8];
    r.last = l;
    if (l) begin
      ks_pos    = 3'd0;
      blk_count = 64'd0;
    end else begin
      ks_pos = ks_pos + 3'd1;
    end
    return r;
  endfunction

  function automatic int unsigned send_idle_pct(input idle_mode_t m);
    case (m)
      IDLE_SEND: return 79;
      IDLE_BOTH: return 24;
      default:   return 0;
    endcase
  endfunction

  function automatic int unsigned recv_stall_pct(input idle_mode_t m);
    case (m)
      IDLE_RECV: return 79;
      IDLE_BOTH: return 24;
      default:   return 0;
    endcase
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(5))
      0:       return 64'd0;
      1:       return '1;
      2:       return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(12));
      default: return rand64();
    endcase
  endfunction

  function automatic int unsigned pick_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 75) return $urandom_range(12, 1);
    if (p < 95) return $urandom_range(40, 13);
    return $urandom_range(100, 41);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < MAX_PRINTS)
      $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // caller drops cfg_we at the next falling edge after the last write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_KEY_WORD_0:    key_w0   = val[31:0];
      REG_KEY_WORD_1:    key_w1   = val[31:0];
      REG_KEY_WORD_2:    key_w2   = val[31:0];
      REG_KEY_WORD_3:    key_w3   = val[31:0];
      REG_START_COUNTER: ctr_base = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one transaction on the input channel; typed_last overrides the predicted flag
  task automatic send_byte(input logic [7:0] d, input logic l,
                           input logic use_typed, input logic typed_last);
    cipher_out_t want;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct(idle_mode)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= d;
    msg_last  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = cipher_step(d, l);
    if (use_typed) want.last = typed_last;
    expected_q.push_back(want);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic walk_table();
    for (int i = 0; i < DIR_ROWS; i++)
      send_byte(byte_table[i].data, byte_table[i].last, 1'b1, byte_table[i].want_last);
    stop_sending();
    wait_drain();
  endtask

  // phase 0: all zero, phase 1: all ones, phase 2: counter just below wrap
  task automatic program_phase(input int unsigned ph);
    logic [63:0] val;
    for (int i = 0; i <= REG_START_COUNTER; i++) begin
      if (ph >= 3 && $urandom_range(2) == 0) continue;
      case (ph)
        0:       val = 64'd0;
        1:       val = '1;
        2:       val = (i == REG_START_COUNTER) ?
                       64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(20)) : rand64();
        default: val = pick_value();
      endcase
      write_reg(CFG_INDEX_W'(i), val);
    end
    if ($urandom_range(3) == 0)
      write_reg(CFG_INDEX_W'(REG_START_COUNTER + 1 + $urandom_range(2)), rand64());
    end_writes();
  endtask

  // receiver: long hold-off when requested, else random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct(idle_mode));
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("transaction with nothing pending", 64'({out_last, out_byte}), 64'd0);
      end else begin
        head_r = expected_q.pop_front();
        if (out_byte !== head_r.data) report_mismatch("out_byte", 64'(out_byte), 64'(head_r.data));
        if (out_last !== head_r.last) report_mismatch("out_last", 64'(out_last), 64'(head_r.last));
      end
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    data_byte = '0;
    msg_last  = 1'b0;
    out_ready = 1'b0;
    key_w0    = '0;
    key_w1    = '0;
    key_w2    = '0;
    key_w3    = '0;
    ctr_base  = '0;
    ks_block  = '0;
    ks_pos    = '0;
    blk_count = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset configuration first
    walk_table();

    // extremes while a message is open; out-of-range indexes must be ignored
    write_reg(REG_KEY_WORD_0, '1);
    write_reg(REG_KEY_WORD_1, '1);
    write_reg(REG_KEY_WORD_2, '1);
    write_reg(REG_KEY_WORD_3, '1);
    write_reg(REG_START_COUNTER, '1);
    for (int j = REG_START_COUNTER + 1; j < (1 << CFG_INDEX_W); j++)
      write_reg(CFG_INDEX_W'(j), 64'd0);
    end_writes();
    walk_table();

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      idle_mode = idle_mode_t'(ph == 4 ? IDLE_NONE : ph % 4);
      if (ph == 4) hold_left = HOLD_CYCLES;
      program_phase(ph);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (msg_left == 0) msg_left = pick_len();
        send_byte(pick_byte(), msg_left == 1, 1'b0, 1'b0);
        msg_left--;
      end
      stop_sending();
      wait_drain();
    end

    idle_mode = IDLE_NONE;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tea_counter_mode_stream_cipher_top verification clean");
    end else begin
      $display("tea_counter_mode_stream_cipher_top verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tea_counter_mode_stream_cipher_top verification failed");
    $finish;
  end

endmodule

### files.f
hdl/tctr_pkg.sv
hdl/tctr_cell.sv
hdl/tctr_ctrl.sv
hdl/tea_counter_mode_stream_cipher_top.sv
test/tea_counter_mode_stream_cipher_top_tb.sv
